// ----- hw/rtl/tss_pkg.sv -----
// shared types and constants for the tone step sequencer
package tss_pkg;

  // command carried by each input word
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  localparam int unsigned FreqWidth = 16;
  localparam int unsigned DurWidth  = 16;
  localparam int unsigned GapWidth  = 16;

  // gap length after reset, in ticks
  localparam logic [GapWidth-1:0] GapTicksReset = 16'd30;

  // one table entry
  typedef struct packed {
    logic [FreqWidth-1:0] freq;
    logic [DurWidth-1:0]  dur;
  } step_t;

  // one result word
  typedef struct packed {
    logic [FreqWidth-1:0] tone_frequency;
    logic                 tone_enable;
    logic                 playing;
    logic                 finished;
    logic                 append_overflow;
  } result_t;

endpackage

// ----- hw/rtl/tone_step_sequencer.sv -----
// tone step sequencer: step table, playback timing and result skid buffer
//
// plays a table of (frequency, duration) steps with a programmable silent gap after each
// step. every input word is one command: a millisecond tick, an append, a start or a clear.
// exactly one result word comes back per input word, from the result register or, while
// the output is stalled, the skid register; a new word can be taken every cycle unless
// the input is stalled: the only loop is the playback state register. the step table
// sits in a small ram with one write port (appends) and one registered read port; the
// read port always fetches the entry after the current step, so the step that follows a
// gap is ready the moment the gap ends, and step 0 is kept in a separate register for a
// start. a two-deep output stage (result register plus skid register) lets the input
// keep flowing while one result waits; the input stall comes straight from a flop. no
// clearing pass is needed after reset, as only entries below the step count are ever
// used. gap_ticks is written through cfg_we_i/cfg_wdata_i and resets to 30.
module tone_step_sequencer #(
  parameter int unsigned MAX_STEPS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] step_frequency_i,
  input  logic [15:0] step_duration_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] tone_frequency_o,
  output logic        tone_enable_o,
  output logic        playing_o,
  output logic        finished_o,
  output logic        append_overflow_o
);

  localparam int unsigned AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int unsigned CW = $clog2(MAX_STEPS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_STEPS);

  // configuration register
  logic [tss_pkg::GapWidth-1:0] gap_ticks_q;

  // playback state
  logic [CW-1:0]                step_cnt_q, step_cnt_d;
  logic [CW-1:0]                step_idx_q, step_idx_d;
  logic [tss_pkg::DurWidth-1:0] elapsed_q, elapsed_d;
  logic                         in_gap_q, in_gap_d;
  logic                         active_q, active_d;

  // step 0, current step and prefetched next step
  tss_pkg::step_t first_q, first_d;
  tss_pkg::step_t cur_q, cur_d;
  tss_pkg::step_t nxt_q;

  // step table
  tss_pkg::step_t step_mem [MAX_STEPS];
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  logic [CW-1:0]  idx_next;
  tss_pkg::step_t new_step;

  // handshake and result stage
  logic             accept;
  tss_pkg::result_t res_d;
  tss_pkg::result_t out_q;
  tss_pkg::result_t skid_q;
  logic             out_vld_q;
  logic             skid_vld_q;

  logic [tss_pkg::DurWidth-1:0] elapsed_inc;
  logic                         finished;
  logic                         overflow;

  assign accept   = in_valid_i && !skid_vld_q;
  assign new_step = '{freq: step_frequency_i, dur: step_duration_i};

  // saturating tick count
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    step_cnt_d = step_cnt_q;
    step_idx_d = step_idx_q;
    elapsed_d  = elapsed_q;
    in_gap_d   = in_gap_q;
    active_d   = active_q;
    first_d    = first_q;
    cur_d      = cur_q;
    mem_we     = 1'b0;
    finished   = 1'b0;
    overflow   = 1'b0;
    if (accept) begin
      unique case (tss_pkg::op_e'(operation_i))
        tss_pkg::OP_TICK: begin
          if (active_q) begin
            if (!in_gap_q) begin
              // sounding phase ends once the duration is reached
              if (elapsed_inc >= cur_q.dur) begin
                in_gap_d  = 1'b1;
                elapsed_d = '0;
              end else begin
                elapsed_d = elapsed_inc;
              end
            end else if (elapsed_inc >= gap_ticks_q) begin
              // gap over: move to the next step or stop after the last one
              step_idx_d = step_idx_q + CW'(1);
              elapsed_d  = '0;
              in_gap_d   = 1'b0;
              cur_d      = nxt_q;
              if (step_idx_q + CW'(1) >= step_cnt_q) begin
                active_d   = 1'b0;
                step_cnt_d = '0;
                finished   = 1'b1;
              end
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
        end
        tss_pkg::OP_APPEND: begin
          if (step_cnt_q < MaxCount) begin
            mem_we     = 1'b1;
            step_cnt_d = step_cnt_q + CW'(1);
            if (step_cnt_q == '0) begin
              first_d = new_step;
            end
          end else begin
            overflow = 1'b1;
          end
        end
        tss_pkg::OP_START: begin
          if (step_cnt_q != '0) begin
            active_d   = 1'b1;
            step_idx_d = '0;
            elapsed_d  = '0;
            in_gap_d   = 1'b0;
            cur_d      = first_q;
          end
        end
        tss_pkg::OP_CLEAR: begin
          active_d   = 1'b0;
          step_cnt_d = '0;
          step_idx_d = '0;
          elapsed_d  = '0;
          in_gap_d   = 1'b0;
        end
      endcase
    end
  end

  // result as seen after the word is applied
  always_comb begin
    res_d                 = '0;
    res_d.playing         = active_d;
    res_d.finished        = finished;
    res_d.append_overflow = overflow;
    if (active_d && !in_gap_d) begin
      res_d.tone_frequency = cur_d.freq;
    end
    res_d.tone_enable = (res_d.tone_frequency != '0);
  end

  // prefetch address: the entry after the step that is current after this word
  assign idx_next  = step_idx_d + CW'(1);
  assign mem_raddr = idx_next[AW-1:0];
  assign mem_waddr = step_cnt_q[AW-1:0];

  // step table ram with write-through onto the prefetch port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      step_mem[mem_waddr] <= new_step;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      nxt_q <= new_step;
    end else begin
      nxt_q <= step_mem[mem_raddr];
    end
  end

  // step payload registers
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    cur_q   <= cur_d;
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q <= tss_pkg::GapTicksReset;
      step_cnt_q  <= '0;
      step_idx_q  <= '0;
      elapsed_q   <= '0;
      in_gap_q    <= 1'b0;
      active_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        gap_ticks_q <= cfg_wdata_i;
      end
      step_cnt_q <= step_cnt_d;
      step_idx_q <= step_idx_d;
      elapsed_q  <= elapsed_d;
      in_gap_q   <= in_gap_d;
      active_q   <= active_d;
    end
  end

  // result register and skid register; the skid only fills while the output is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (!out_vld_q || !out_stall_i) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_vld_q && out_stall_i) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (!out_vld_q || !out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_vld_q && out_stall_i) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign in_stall_o        = skid_vld_q;
  assign out_valid_o       = out_vld_q;
  assign tone_frequency_o  = out_q.tone_frequency;
  assign tone_enable_o     = out_q.tone_enable;
  assign playing_o         = out_q.playing;
  assign finished_o        = out_q.finished;
  assign append_overflow_o = out_q.append_overflow;

  // a running sequence always points at a stored step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (step_idx_q < step_cnt_q))
    else $error("step index outside the table while playing");

  // the table never holds more steps than it has room for
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_cnt_q <= MaxCount)
    else $error("step count beyond table depth");

  // the skid register is only used behind a full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word without result word");

  // a finishing word ends playback and carries no tone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.finished) |-> (!out_q.playing && !out_q.tone_enable))
    else $error("finished word still playing");

  // an overflowing append never changes the step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && overflow) |=> (step_cnt_q == MaxCount))
    else $error("step count moved on overflowing append");

endmodule

// ----- sim/tone_step_sequencer_checker.sv -----
// watches both channels of the tone step sequencer, predicts each result word and compares
module tone_step_sequencer_checker #(
  parameter int unsigned MAX_STEPS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  operation_i,
  input  logic [15:0] step_frequency_i,
  input  logic [15:0] step_duration_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] tone_frequency_i,
  input  logic        tone_enable_i,
  input  logic        playing_i,
  input  logic        finished_i,
  input  logic        append_overflow_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          useful_words_o,
  output int          results_checked_o,
  output int          finishes_o,
  output int          refusals_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // own copy of the player
  tss_pkg::step_t steps [MAX_STEPS];
  int             n_steps;
  int             cur_step;
  logic [15:0]    tick_count;
  logic           gap_phase;
  logic           running;
  logic [15:0]    gap_len;

  tss_pkg::result_t expected_q [$];

  initial begin
    fail_count_o      = 0;
    pending_o         = 0;
    useful_words_o    = 0;
    results_checked_o = 0;
    finishes_o        = 0;
    refusals_o        = 0;
    gap_len           = tss_pkg::GapTicksReset;
  end

  task automatic reset_player();
    foreach (steps[i]) steps[i] = '0;
    n_steps    = 0;
    cur_step   = 0;
    tick_count = '0;
    gap_phase  = 1'b0;
    running    = 1'b0;
    gap_len    = tss_pkg::GapTicksReset;
  endtask

  // applies one word to the player and returns the word it should answer with
  function automatic tss_pkg::result_t advance_player(tss_pkg::op_e op, logic [15:0] freq,
                                                      logic [15:0] dur);
    tss_pkg::result_t r;
    r = '0;
    case (op)
      tss_pkg::OP_TICK: begin
        if (running) begin
          if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
          if (!gap_phase) begin
            if (tick_count >= steps[cur_step].dur) begin
              gap_phase  = 1'b1;
              tick_count = '0;
            end
          end else if (tick_count >= gap_len) begin
            cur_step   = cur_step + 1;
            tick_count = '0;
            gap_phase  = 1'b0;
            if (cur_step >= n_steps) begin
              running    = 1'b0;
              n_steps    = 0;
              r.finished = 1'b1;
            end
          end
        end
      end
      tss_pkg::OP_APPEND: begin
        if (n_steps < MAX_STEPS) begin
          steps[n_steps].freq = freq;
          steps[n_steps].dur  = dur;
          n_steps = n_steps + 1;
        end else begin
          r.append_overflow = 1'b1;
        end
      end
      tss_pkg::OP_START: begin
        if (n_steps > 0) begin
          running    = 1'b1;
          cur_step   = 0;
          tick_count = '0;
          gap_phase  = 1'b0;
        end
      end
      default: begin
        running    = 1'b0;
        n_steps    = 0;
        cur_step   = 0;
        tick_count = '0;
        gap_phase  = 1'b0;
      end
    endcase
    if (running && !gap_phase && cur_step < MAX_STEPS) r.tone_frequency = steps[cur_step].freq;
    r.tone_enable = (r.tone_frequency != '0);
    r.playing     = running;
    return r;
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      fail_count_o = fail_count_o + 1;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    tss_pkg::result_t seen;
    tss_pkg::result_t want;
    tss_pkg::op_e     op;
    if (!rst_ni) begin
      reset_player();
      expected_q.delete();
    end else begin
      if (cfg_we_i) gap_len = cfg_wdata_i;
      // a result word is never caused by the word taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        seen.tone_frequency  = tone_frequency_i;
        seen.tone_enable     = tone_enable_i;
        seen.playing         = playing_i;
        seen.finished        = finished_i;
        seen.append_overflow = append_overflow_i;
        if (expected_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t ns: result word with none expected, got %h", $time, seen);
        end else begin
          want = expected_q.pop_front();
          results_checked_o = results_checked_o + 1;
          check_field("tone_frequency", want.tone_frequency, seen.tone_frequency);
          check_field("tone_enable", want.tone_enable, seen.tone_enable);
          check_field("playing", want.playing, seen.playing);
          check_field("finished", want.finished, seen.finished);
          check_field("append_overflow", want.append_overflow, seen.append_overflow);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        op = tss_pkg::op_e'(operation_i);
        if (!((op == tss_pkg::OP_TICK && !running) ||
              (op == tss_pkg::OP_START && n_steps == 0)))
          useful_words_o = useful_words_o + 1;
        want = advance_player(op, step_frequency_i, step_duration_i);
        if (want.finished) finishes_o = finishes_o + 1;
        if (want.append_overflow) refusals_o = refusals_o + 1;
        expected_q.push_back(want);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- sim/tone_step_sequencer_test.sv -----
// top of the tone step sequencer testbench: clock, reset, stimulus and verdict
module tone_step_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSteps   = 32;
  localparam int          CycleLimit = 600000;
  localparam int          RandomWords = 1150;
  localparam int          LongHold   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = tss_pkg::OP_TICK;
  logic [15:0] step_frequency = '0;
  logic [15:0] step_duration = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] tone_frequency;
  logic        tone_enable;
  logic        playing;
  logic        finished;
  logic        append_overflow;

  int fail_count;
  int pending_results;
  int useful_words;
  int results_checked;
  int finishes;
  int refusals;

  int          cycle_count = 0;
  int          words_sent = 0;
  int          gap_writes = 0;
  logic [15:0] gap_now = tss_pkg::GapTicksReset;
  // per phase: no idling on that side
  bit          calm_sender = 1'b0;
  bit          calm_receiver = 1'b0;
  // asks the result side for one long hold-off
  bit          long_hold_req = 1'b0;

  tone_step_sequencer #(.MAX_STEPS(MaxSteps)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .step_frequency_i  (step_frequency),
    .step_duration_i   (step_duration),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .tone_frequency_o  (tone_frequency),
    .tone_enable_o     (tone_enable),
    .playing_o         (playing),
    .finished_o        (finished),
    .append_overflow_o (append_overflow)
  );

  tone_step_sequencer_checker #(.MAX_STEPS(MaxSteps)) scoreboard (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .operation_i       (operation),
    .step_frequency_i  (step_frequency),
    .step_duration_i   (step_duration),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .tone_frequency_i  (tone_frequency),
    .tone_enable_i     (tone_enable),
    .playing_i         (playing),
    .finished_i        (finished),
    .append_overflow_i (append_overflow),
    .fail_count_o      (fail_count),
    .pending_o         (pending_results),
    .useful_words_o    (useful_words),
    .results_checked_o (results_checked),
    .finishes_o        (finishes),
    .refusals_o        (refusals)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count = cycle_count + 1;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending_results);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int next_idle(bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // offers one word and returns at the falling edge after it was taken
  task automatic send_word(tss_pkg::op_e op, logic [15:0] freq, logic [15:0] dur);
    int idle;
    idle = next_idle(calm_sender);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    step_frequency <= freq;
    step_duration  <= dur;
    do @(posedge clk_i); while (in_stall);
    words_sent = words_sent + 1;
    @(negedge clk_i);
  endtask

  // stops offering and waits until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
  endtask

  // register write, only ever called once drained
  task automatic write_gap(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    gap_now    = value;
    gap_writes = gap_writes + 1;
  endtask

  function automatic logic [15:0] pick_gap();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      3:       return tss_pkg::GapTicksReset;
      default: return 16'($urandom_range(0, 5));
    endcase
  endfunction

  // one well formed sequence: optional gap write and clear, a run of appends, a start, then ticks,
  // with a little noise mixed into the ticks
  task automatic play_phase();
    int          n_app;
    int          n_ticks;
    logic [15:0] dur;
    drain();
    calm_sender   = ($urandom_range(0, 3) == 0);
    calm_receiver = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 2) == 0) write_gap(pick_gap());
    if ($urandom_range(0, 3) != 0)
      send_word(tss_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
    // now and then enough appends to run past the end of the table
    n_app   = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 6);
    n_ticks = 0;
    for (int i = 0; i < n_app; i++) begin
      dur = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      send_word(tss_pkg::OP_APPEND, 16'($urandom), dur);
      n_ticks += ((dur > 200) ? 200 : dur) + ((gap_now > 200) ? 200 : gap_now) + 2;
    end
    send_word(tss_pkg::OP_START, 16'($urandom), 16'($urandom));
    if (n_ticks > 400) n_ticks = 400;
    n_ticks += $urandom_range(0, 3);
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_word(tss_pkg::op_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
      else
        send_word(tss_pkg::OP_TICK, 16'($urandom), 16'($urandom));
    end
  endtask

  // result side: random stall before each word, plus one long hold-off on request
  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = next_idle(calm_receiver);
      if (long_hold_req) begin
        hold          = LongHold;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int phase;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle behaviour: tick with nothing playing, start with an empty table
    send_word(tss_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
    send_word(tss_pkg::OP_START, 16'h0000, 16'h0000);
    // highest step with zero duration, a rest, then the lowest audible step
    send_word(tss_pkg::OP_APPEND, 16'hFFFF, 16'h0000);
    send_word(tss_pkg::OP_APPEND, 16'h0000, 16'h0001);
    send_word(tss_pkg::OP_APPEND, 16'h0001, 16'h0002);
    drain();
    // zero gap still costs one tick
    write_gap(16'h0000);
    send_word(tss_pkg::OP_START, 16'h0000, 16'h0000);
    repeat (7) send_word(tss_pkg::OP_TICK, 16'h0000, 16'h0000);
    // back to idle after the last gap
    send_word(tss_pkg::OP_TICK, 16'h0000, 16'h0000);
    drain();
    // widest gap, longest duration, append and restart while playing, then clear
    write_gap(16'hFFFF);
    send_word(tss_pkg::OP_APPEND, 16'hA5A5, 16'hFFFF);
    send_word(tss_pkg::OP_APPEND, 16'h5A5A, 16'h8000);
    send_word(tss_pkg::OP_START, 16'hFFFF, 16'hFFFF);
    send_word(tss_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(tss_pkg::OP_APPEND, 16'h0001, 16'h0003);
    send_word(tss_pkg::OP_START, 16'h0000, 16'h0000);
    send_word(tss_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_word(tss_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
    send_word(tss_pkg::OP_TICK, 16'h0000, 16'h0000);

    // random sequences until enough words have been sent
    phase = 0;
    while (words_sent < RandomWords) begin
      play_phase();
      phase = phase + 1;
      // fill the block up: the result side holds off while words keep coming
      if (phase == 3) begin
        drain();
        long_hold_req = 1'b1;
        calm_sender   = 1'b1;
        repeat (40) send_word(tss_pkg::OP_TICK, 16'($urandom), 16'($urandom));
      end
    end

    drain();
    repeat (5) @(posedge clk_i);
    $display("covered %0d phases, %0d words sent, %0d effective, %0d result words compared",
             phase, words_sent, useful_words, results_checked);
    $display("%0d sequences played out, %0d appends refused, %0d gap settings written",
             finishes, refusals, gap_writes);
    if (fail_count == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tss_pkg.sv
hw/rtl/tone_step_sequencer.sv
sim/tone_step_sequencer_checker.sv
sim/tone_step_sequencer_test.sv
